// ----- sv/rdx_pkg.sv -----
package rdx_pkg;

    localparam int DEF_INT_BITS  = 32;
    localparam int DEF_FRAC_BITS = 16;

    localparam int CFG_W  = 5;
    localparam int CHAR_W = 7;

    // register indexes
    localparam logic REG_BASE = 1'b0;
    localparam logic REG_PREC = 1'b1;

    localparam logic [CFG_W-1:0] BASE_RESET = 5'd10;
    localparam logic [CFG_W-1:0] PREC_RESET = 5'd2;
    localparam logic [CFG_W-1:0] BASE_MIN   = 5'd2;
    localparam logic [CFG_W-1:0] BASE_MAX   = 5'd16;
    localparam logic [CFG_W-1:0] PREC_MAX   = 5'd16;

    localparam logic [3:0] DEC_TEN = 4'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_F     = 7'h46;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 7'h2C;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIGN,
        S_ZERO,
        S_DIV,
        S_INT_OUT,
        S_COMMA,
        S_FRAC
    } t_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_TEN) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DEC_TEN);
        end
        return c;
    endfunction

endpackage

// ----- sv/rdx_in_if.sv -----
interface rdx_in_if import rdx_pkg::*; #(
    parameter int VALUE_W = DEF_INT_BITS + DEF_FRAC_BITS
) ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- sv/rdx_out_if.sv -----
interface rdx_out_if import rdx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- sv/rdx_div_step.sv -----
// One long-division step: remainder and next nibble of the dividend in,
// quotient nibble and new remainder out. Remainder stays below the base.
module rdx_div_step import rdx_pkg::*; (
    input  logic [3:0]       i_rem,
    input  logic [3:0]       i_nib,
    input  logic [CFG_W-1:0] i_base,
    output logic [3:0]       o_quo,
    output logic [3:0]       o_rem
);

    logic [8:0] w_t;
    logic [3:0] w_q;

    always_comb begin
        w_t = {1'b0, i_rem, i_nib};
        w_q = '0;
        for (int k = 3; k >= 0; k--) begin
            if (w_t >= (9'(i_base) << k)) begin
                w_t    = w_t - (9'(i_base) << k);
                w_q[k] = 1'b1;
            end
        end
    end

    assign o_quo = w_q;
    assign o_rem = w_t[3:0];

endmodule

// ----- sv/fixed_to_radix_digits.sv -----
// Renders one signed fixed-point value (INT_BITS integer bits, FRAC_BITS
// fraction bits) as ASCII text in base 2..16, one character per output item,
// with last set on the final one: optional '-', integer digits most
// significant first (or a single '0'), then ',' and up to 'precision'
// truncated fraction digits when the fraction is nonzero. Integer digits come
// from one shared divide unit that consumes one dividend nibble per cycle, so
// each integer digit takes a pass over all ceil(INT_BITS/4) dividend nibbles
// (8 for Q32.16); every character then leaves through the output register,
// fraction digits using one multiply by the base each. The input is not
// ready until the last character has been loaded into the output register.
module fixed_to_radix_digits import rdx_pkg::*; #(
    parameter int INT_BITS  = DEF_INT_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    rdx_in_if.sink           i_in_ch,
    rdx_out_if.source        o_out_ch
);

    localparam int VW  = INT_BITS + FRAC_BITS;
    localparam int NIB = (INT_BITS + 3) / 4;
    localparam int QW  = NIB * 4;
    localparam int SCW = $clog2(NIB);
    localparam int NCW = $clog2(INT_BITS + 1);
    localparam int AW  = $clog2(INT_BITS);
    localparam int PW  = FRAC_BITS + CFG_W;

    t_state r_state, n_state;

    logic [CFG_W-1:0]     r_base, r_prec;
    logic [CFG_W-1:0]     r_b, r_p, r_fcnt;
    logic [QW-1:0]        r_quot;
    logic [3:0]           r_rem;
    logic [SCW-1:0]       r_scnt;
    logic [NCW-1:0]       r_nd;
    logic [FRAC_BITS-1:0] r_frac;
    logic [3:0]           r_buf [INT_BITS];

    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;

    logic [VW-1:0]        w_value, w_mag;
    logic                 w_neg;
    logic [INT_BITS-1:0]  w_ipart;
    logic [FRAC_BITS-1:0] w_fpart;
    logic [CFG_W-1:0]     w_b_sat, w_p_sat;
    logic                 w_in_acc;

    logic [3:0]           w_quo, w_rem_next;
    logic [QW-1:0]        w_quot_next;
    logic                 w_div_last;

    logic [NCW-1:0]       w_nd_m1;
    logic [3:0]           w_rd_digit;
    logic [PW-1:0]        w_prod;
    logic [3:0]           w_fdigit;
    logic [FRAC_BITS-1:0] w_frac_next;
    logic                 w_frac_end;

    logic              w_slot, w_emit, w_last;
    logic [CHAR_W-1:0] w_char;

    // input side
    assign w_value  = VW'(i_in_ch.value);
    assign w_neg    = w_value[VW-1];
    assign w_mag    = w_neg ? (~w_value + VW'(1)) : w_value;
    assign w_ipart  = w_mag[VW-1:FRAC_BITS];
    assign w_fpart  = w_mag[FRAC_BITS-1:0];
    assign w_in_acc = i_in_ch.valid && (r_state == S_IDLE);
    assign i_in_ch.ready = (r_state == S_IDLE);

    assign w_b_sat = (r_base < BASE_MIN) ? BASE_MIN :
                     (r_base > BASE_MAX) ? BASE_MAX : r_base;
    assign w_p_sat = (r_prec > PREC_MAX) ? PREC_MAX : r_prec;

    // shared divide unit, one dividend nibble per cycle from the top
    rdx_div_step u_div (
        .i_rem  (r_rem),
        .i_nib  (r_quot[QW-1 -: 4]),
        .i_base (r_b),
        .o_quo  (w_quo),
        .o_rem  (w_rem_next)
    );

    assign w_quot_next = {r_quot[QW-5:0], w_quo};
    assign w_div_last  = (r_scnt == SCW'(NIB - 1));

    assign w_nd_m1    = r_nd - NCW'(1);
    assign w_rd_digit = r_buf[w_nd_m1[AW-1:0]];

    assign w_prod      = PW'(r_frac) * PW'(r_b);
    assign w_fdigit    = w_prod[FRAC_BITS+3:FRAC_BITS];
    assign w_frac_next = w_prod[FRAC_BITS-1:0];
    assign w_frac_end  = (w_frac_next == '0) || ((r_fcnt + CFG_W'(1)) == r_p);

    assign w_slot = !r_out_valid || o_out_ch.ready;

    // character selection
    always_comb begin
        w_emit = 1'b0;
        w_char = CHAR_ZERO;
        w_last = 1'b0;
        unique case (r_state)
            S_SIGN: begin
                w_emit = w_slot;
                w_char = CHAR_MINUS;
            end
            S_ZERO: begin
                w_emit = w_slot;
                w_char = CHAR_ZERO;
                w_last = (r_frac == '0);
            end
            S_INT_OUT: begin
                w_emit = w_slot;
                w_char = digit_char(w_rd_digit);
                w_last = (r_nd == NCW'(1)) && (r_frac == '0);
            end
            S_COMMA: begin
                w_emit = w_slot;
                w_char = CHAR_COMMA;
                w_last = (r_p == '0);
            end
            S_FRAC: begin
                w_emit = w_slot;
                w_char = digit_char(w_fdigit);
                w_last = w_frac_end;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_neg)              n_state = S_SIGN;
                    else if (w_ipart == '0) n_state = S_ZERO;
                    else                    n_state = S_DIV;
                end
            end
            S_SIGN: begin
                if (w_emit) n_state = (r_quot == '0) ? S_ZERO : S_DIV;
            end
            S_ZERO: begin
                if (w_emit) n_state = (r_frac != '0) ? S_COMMA : S_IDLE;
            end
            S_DIV: begin
                if (w_div_last && (w_quot_next == '0)) n_state = S_INT_OUT;
            end
            S_INT_OUT: begin
                if (w_emit && (r_nd == NCW'(1))) begin
                    n_state = (r_frac != '0) ? S_COMMA : S_IDLE;
                end
            end
            S_COMMA: begin
                if (w_emit) n_state = (r_p == '0) ? S_IDLE : S_FRAC;
            end
            S_FRAC: begin
                if (w_emit && w_frac_end) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_base      <= BASE_RESET;
            r_prec      <= PREC_RESET;
        end else begin
            r_state <= n_state;
            if (w_emit)              r_out_valid <= 1'b1;
            else if (o_out_ch.ready) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_BASE) r_base <= i_cfg_data;
                else                       r_prec <= i_cfg_data;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_char <= w_char;
            r_out_last <= w_last;
        end
        if (w_in_acc) begin
            r_quot <= QW'(w_ipart);
            r_frac <= w_fpart;
            r_b    <= w_b_sat;
            r_p    <= w_p_sat;
            r_rem  <= '0;
            r_scnt <= '0;
            r_nd   <= '0;
        end else begin
            unique case (r_state)
                S_DIV: begin
                    r_quot <= w_quot_next;
                    if (w_div_last) begin
                        r_buf[r_nd[AW-1:0]] <= w_rem_next;
                        r_nd   <= r_nd + NCW'(1);
                        r_rem  <= '0;
                        r_scnt <= '0;
                    end else begin
                        r_rem  <= w_rem_next;
                        r_scnt <= r_scnt + SCW'(1);
                    end
                end
                S_INT_OUT: begin
                    if (w_emit) r_nd <= w_nd_m1;
                end
                S_COMMA: begin
                    if (w_emit) r_fcnt <= '0;
                end
                S_FRAC: begin
                    if (w_emit) begin
                        r_frac <= w_frac_next;
                        r_fcnt <= r_fcnt + CFG_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_ch.valid     = r_out_valid;
    assign o_out_ch.char_code = r_out_char;
    assign o_out_ch.last      = r_out_last;

endmodule

// ----- sv/rdx_check.sv -----
module rdx_check import rdx_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CHAR_W-1:0] i_out_char,
    input logic              i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_char) && $stable(i_out_last))
        else $error("stalled output item changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    a_busy_mid_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready while text of an item is unfinished");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ((i_out_char >= CHAR_ZERO) && (i_out_char <= CHAR_NINE)) ||
            ((i_out_char >= CHAR_A) && (i_out_char <= CHAR_F)) ||
            (i_out_char == CHAR_MINUS) || (i_out_char == CHAR_COMMA))
        else $error("output character outside the digit set");

endmodule

bind fixed_to_radix_digits rdx_check u_rdx_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_char  (o_out_ch.char_code),
    .i_out_last  (o_out_ch.last)
);

// ----- tb/sv/fixed_to_radix_digits_tb.sv -----
`timescale 1ns / 1ps

module fixed_to_radix_digits_tb;
    import rdx_pkg::*;

    localparam int VALUE_W       = DEF_INT_BITS + DEF_FRAC_BITS;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 7;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASES        = 8;
    localparam int PHASE_VALUES  = 48;

    localparam logic [VALUE_W-1:0] MAX_VALUE = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] MIN_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    rdx_in_if #(.VALUE_W(VALUE_W)) in_ch ();
    rdx_out_if out_ch ();

    fixed_to_radix_digits #(
        .INT_BITS  (DEF_INT_BITS),
        .FRAC_BITS (DEF_FRAC_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    t_text_char       pending_text[$];
    logic [CFG_W-1:0] cur_base;
    logic [CFG_W-1:0] cur_prec;
    logic             calm;
    int unsigned      hold_requests;
    int unsigned      error_count  = 0;
    int unsigned      values_sent  = 0;
    int unsigned      chars_seen   = 0;
    int unsigned      cycle_count  = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d characters still expected", $time, pending_text.size());
            $display("[fixed_to_radix_digits] ERROR");
            $finish;
        end
    end

    function automatic logic [CHAR_W-1:0] ascii_digit(input logic [3:0] d);
        if (d < 4'd10) begin
            return CHAR_ZERO + CHAR_W'(d);
        end
        return CHAR_A + CHAR_W'(d - 4'd10);
    endfunction

    // Build the full text of one value under the current format and queue it.
    function automatic void predict_text(input logic [VALUE_W-1:0] raw);
        logic                      neg;
        logic [VALUE_W-1:0]        mag;
        logic [DEF_INT_BITS-1:0]   whole;
        logic [DEF_FRAC_BITS-1:0]  frac;
        logic [DEF_FRAC_BITS+4:0]  prod;
        int unsigned               radix;
        int unsigned               places;
        logic [3:0]                int_digits[$];
        t_text_char                text[$];

        neg   = raw[VALUE_W-1];
        mag   = neg ? (~raw + 1'b1) : raw;
        whole = mag[VALUE_W-1:DEF_FRAC_BITS];
        frac  = mag[DEF_FRAC_BITS-1:0];
        radix = 32'((cur_base < BASE_MIN) ? BASE_MIN :
                    (cur_base > BASE_MAX) ? BASE_MAX : cur_base);
        places = 32'((cur_prec > PREC_MAX) ? PREC_MAX : cur_prec);

        if (neg) begin
            text.push_back('{CHAR_MINUS, 1'b0});
        end
        if (whole == 0) begin
            text.push_back('{CHAR_ZERO, 1'b0});
        end
        while (whole != 0) begin
            int_digits.push_front(4'(whole % radix));
            whole = whole / radix;
        end
        foreach (int_digits[i]) begin
            text.push_back('{ascii_digit(int_digits[i]), 1'b0});
        end
        if (frac != 0) begin
            text.push_back('{CHAR_COMMA, 1'b0});
            // truncate, and stop once the remaining fraction runs out
            for (int i = 0; i < places && frac != 0; i++) begin
                prod = (DEF_FRAC_BITS+5)'(frac * radix);
                text.push_back('{ascii_digit(prod[DEF_FRAC_BITS+3:DEF_FRAC_BITS]), 1'b0});
                frac = prod[DEF_FRAC_BITS-1:0];
            end
        end
        text[text.size()-1].last = 1'b1;
        foreach (text[i]) begin
            pending_text.push_back(text[i]);
        end
    endfunction

    // Receiver: random stalls, a counted hold-off on request, none while calm.
    initial begin : sink_side
        int unsigned hold_served;
        int unsigned hold_left;
        hold_served = 0;
        hold_left   = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            chars_seen++;
            if (pending_text.size() == 0) begin
                error_count++;
                $display("%0t: unexpected char expected none actual %h last %b",
                         $time, out_ch.char_code, out_ch.last);
            end else begin
                want = pending_text.pop_front();
                if (want.code !== out_ch.char_code) begin
                    error_count++;
                    $display("%0t: char_code expected %h actual %h",
                             $time, want.code, out_ch.char_code);
                end
                if (want.last !== out_ch.last) begin
                    error_count++;
                    $display("%0t: last expected %b actual %b", $time, want.last, out_ch.last);
                end
            end
        end
    end

    task automatic send_value(input logic [VALUE_W-1:0] v);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_text(v);
        values_sent++;
    endtask

    // Drop valid and let every queued character drain before touching registers.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_text.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_BASE) begin
            cur_base = data;
        end else begin
            cur_prec = data;
        end
        @(posedge i_clk);
    endtask

    task automatic set_format(input logic [CFG_W-1:0] radix, input logic [CFG_W-1:0] places);
        write_reg(REG_BASE, radix);
        write_reg(REG_PREC, places);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [63:0]        wide;
        logic [VALUE_W-1:0] v;
        wide = {$urandom(), $urandom()};
        case ($urandom_range(0, 5))
            0: v = wide[VALUE_W-1:0];
            1: v = {DEF_INT_BITS'($urandom_range(0, 999)), wide[DEF_FRAC_BITS-1:0]};
            2: v = {{DEF_INT_BITS{1'b0}}, wide[DEF_FRAC_BITS-1:0]};
            3: v = {wide[VALUE_W-1:DEF_FRAC_BITS], wide[3:0], {(DEF_FRAC_BITS-4){1'b0}}};
            4: v = {wide[VALUE_W-1:DEF_FRAC_BITS], {DEF_FRAC_BITS{1'b0}}};
            default: v = (wide[0] ? MAX_VALUE : MIN_VALUE) + VALUE_W'(wide[3:1]);
        endcase
        if ($urandom_range(0, 1) == 1) begin
            v = ~v + 1'b1;
        end
        return v;
    endfunction

    // Reset format, signs, zero, extremes and the smallest fraction.
    task automatic test_default_format();
        send_value('0);
        send_value(48'h0000_0001_8000);
        send_value(-48'h0000_0000_8000);
        send_value(48'h0000_3039_4000);
        send_value(MAX_VALUE);
        send_value(MIN_VALUE);
        send_value(-48'h0000_0001_0000);
        send_value(48'h0000_0000_0001);
        wait_idle();
    endtask

    // Saturating register values and zero precision.
    task automatic test_register_extremes();
        set_format(5'd0, 5'd31);
        send_value(MAX_VALUE);
        send_value(-48'h0000_0000_0001);
        wait_idle();
        set_format(5'd1, 5'd17);
        send_value(48'h0000_0005_5555);
        wait_idle();
        set_format(BASE_MAX, PREC_MAX);
        send_value(MIN_VALUE);
        send_value(48'h0000_FFFF_ABCD);
        wait_idle();
        set_format(5'd17, 5'd16);
        send_value(-48'h0000_00FF_0001);
        wait_idle();
        set_format(5'd31, 5'd0);
        send_value(48'h0000_0000_FFFF);
        wait_idle();
        set_format(BASE_RESET, 5'd0);
        send_value(48'h0000_0003_4000);
        send_value(-48'h0000_0000_4000);
        send_value(48'h0000_0007_0000);
        wait_idle();
        set_format(5'd3, 5'd5);
        send_value(48'h0000_0002_5555);
        wait_idle();
    endtask

    // Hold the receiver off while the sender keeps offering values.
    task automatic test_output_stall();
        set_format(BASE_RESET, 5'd4);
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < 10; i++) begin
            send_value(pick_value());
        end
        wait_idle();
    endtask

    task automatic test_random_formats();
        for (int ph = 0; ph < PHASES; ph++) begin
            set_format(($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 31))
                                                   : CFG_W'($urandom_range(2, 16)),
                       ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 31))
                                                   : CFG_W'($urandom_range(0, 16)));
            calm <= (ph == PHASES / 2);
            for (int i = 0; i < PHASE_VALUES; i++) begin
                send_value(pick_value());
            end
            wait_idle();
            calm <= 1'b0;
        end
    endtask

    initial begin
        cur_base = BASE_RESET;
        cur_prec = PREC_RESET;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_BASE;
        i_cfg_data    <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.value   <= '0;
        calm          <= 1'b0;
        hold_requests <= 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_format();
        test_register_extremes();
        test_output_stall();
        test_random_formats();

        $display("Rendered %0d values as %0d characters over bases 2..16 and precisions 0..16,",
                 values_sent, chars_seen);
        $display("with saturating register settings, random stalls and a long output hold-off.");
        if (error_count == 0) begin
            $display("[fixed_to_radix_digits] OK");
        end else begin
            $display("[fixed_to_radix_digits] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/rdx_pkg.sv
sv/rdx_in_if.sv
sv/rdx_out_if.sv
sv/rdx_div_step.sv
sv/fixed_to_radix_digits.sv
sv/rdx_check.sv
tb/sv/fixed_to_radix_digits_tb.sv
